// ===== hw/rtl/kcgp_pkg.sv =====
`default_nettype none
package kcgp_pkg;
  typedef enum logic [2:0] {
    OP_BASE = 3'd0,
    OP_PRUNE_LOW = 3'd1,
    OP_PRUNE_TIPS = 3'd2,
    OP_PRUNE_DIFF = 3'd3,
    OP_PRUNE_SINGLE = 3'd4,
    OP_QUERY = 3'd5,
    OP_MAX_DEPTH = 3'd6,
    OP_UNUSED = 3'd7
  } op_t;

  localparam logic [1:0] REG_KMER_SIZE = 2'd0;
  localparam logic [1:0] REG_MARGIN    = 2'd1;
  localparam logic [1:0] REG_END_MODE  = 2'd2;
  localparam logic [1:0] REG_MIN_DEPTH = 2'd3;

  // read position and read length share the width of the read_length port
  localparam int READ_LEN_BITS = 20;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    case (ch)
      8'h43, 8'h63: base_code = 2'd1;
      8'h47, 8'h67: base_code = 2'd2;
      8'h54, 8'h74: base_code = 2'd3;
      default:      base_code = 2'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/kmer_count_graph_pruner_unit.sv =====
// k-mer counter and graph pruner. The count table (4^MAX_K entries) is a synchronous
// memory with one read and one write per cycle; the mark bits are a second memory. After
// reset the block sweeps the table to zero, one entry per cycle, and holds busy high
// meanwhile. From the edge that accepts a beat, busy stays high while the block steps
// through: for a base, read, write back and finish; for a query, a read of the entry and
// each of its eight neighbours (request, then wait), then evaluate and finish; for max
// depth, read and evaluate for each of the 4^k entries of the current k, then finish; for
// a prune, a mark pass that reads and evaluates each entry (and also its eight neighbours
// unless it is empty or under the low-depth rule), then a clear pass that reads each mark
// and clears marked entries, then finish; for the unused op, finish alone. The result is
// shown for one cycle with done high, in the first cycle with busy low; the receiver cannot
// stall it. Write configuration only while the block is idle; a write takes effect at once.
`default_nettype none
module kmer_count_graph_pruner_unit
  import kcgp_pkg::*;
#(
  parameter int MAX_K = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op,
  input  wire logic [7:0]  base_char,
  input  wire logic        first_of_read,
  input  wire logic [19:0] read_length,
  input  wire logic [15:0] query_kmer,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output logic             done,
  output logic             present,
  output logic [15:0]      kmer_count,
  output logic [3:0]       upstream_mask,
  output logic [3:0]       downstream_mask,
  output logic [15:0]      max_count,
  output logic [16:0]      removed_total
);
  localparam int AW = 2 * MAX_K;
  localparam int KW = $clog2(MAX_K + 1);
  localparam int TW = AW + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [READ_LEN_BITS-1:0] PMAX = '1;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_BASE  = 10'b0000000100,
    S_BWR   = 10'b0000001000,
    S_NREQ  = 10'b0000010000,
    S_NWAIT = 10'b0000100000,
    S_EVAL  = 10'b0001000000,
    S_CREAD = 10'b0010000000,
    S_CWR   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;
  logic [COUNT_BITS-1:0] mem [2**AW];
  logic                  mark_mem [2**AW];
  logic [COUNT_BITS-1:0] rdata;
  logic                  mark_rd;

  logic [3:0]  kbases;
  logic [19:0] margin;
  logic        end_mode;
  logic [15:0] depth_floor;
  logic [AW-1:0] base_window;
  logic [READ_LEN_BITS-1:0] read_position;

  op_t           cur_op;
  logic [TW-1:0] idx;       // walk index, wide enough to hold the end
  logic [3:0]    step;      // 0 self, 1..4 upstream, 5..8 downstream
  logic [AW-1:0] cur;
  logic [COUNT_BITS-1:0] self_c, upmax, downmax, maxc;
  logic          upany, downany, other;
  logic [3:0]    um, dm;
  logic [16:0]   removed;
  logic          ok_base;

  // effective k
  logic [KW-1:0] k;
  always_comb begin
    if (kbases == 4'd0) k = KW'(1);
    else if (32'(kbases) > MAX_K) k = KW'(MAX_K);
    else k = KW'(kbases);
  end

  logic [AW-1:0] kmask;
  assign kmask = AW'(({(AW+1){1'b0}} | (TW'(1) << (2 * k))) - TW'(1));
  logic [TW-1:0] n_ent;
  assign n_ent = TW'(1) << (2 * k);

  // neighbour address for current step
  logic [AW-1:0] nb_addr;
  logic [1:0]    nb_b;
  always_comb begin
    nb_b = 2'(step - 4'd1);
    if (step == 4'd0) nb_addr = cur;
    else if (step <= 4'd4)
      nb_addr = (AW'(nb_b) << (2 * (k - KW'(1)))) | (cur >> 2);
    else begin
      nb_b = 2'(step - 4'd5);
      nb_addr = ((cur << 2) | AW'(nb_b)) & kmask;
    end
  end

  // base handling
  logic [AW-1:0] win_next;
  logic [READ_LEN_BITS-1:0] pos_next, pos_base;
  logic [READ_LEN_BITS:0] len_ext, p_ext, lim;
  logic [AW-1:0] win_base;
  always_comb begin
    win_base = first_of_read ? '0 : base_window;
    pos_base = first_of_read ? '0 : read_position;
    win_next = (win_base << 2) | AW'(base_code(base_char));
    pos_next = (pos_base == PMAX) ? pos_base : pos_base + 1'b1;
    len_ext = (READ_LEN_BITS+1)'(read_length);
    p_ext = (READ_LEN_BITS+1)'(pos_next);
    lim = ((READ_LEN_BITS+1)'(margin) < len_ext) ? (READ_LEN_BITS+1)'(margin) : len_ext;
  end
  logic ok_calc;
  always_comb begin
    if (p_ext < (READ_LEN_BITS+1)'(k)) ok_calc = 1'b0;
    else if (!end_mode) ok_calc = p_ext <= lim;
    else ok_calc = (p_ext <= len_ext) &&
         ((READ_LEN_BITS+2)'(p_ext - (READ_LEN_BITS+1)'(k)) + (READ_LEN_BITS+2)'(margin)
          >= (READ_LEN_BITS+2)'(len_ext));
  end

  // memory port
  logic          we, mwe, mwd;
  logic [AW-1:0] waddr, raddr;
  logic [COUNT_BITS-1:0] wdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
    if (mwe) mark_mem[waddr] <= mwd;
    mark_rd <= mark_mem[raddr];
  end

  // mark decision from gathered neighbour data
  logic mark_now;
  always_comb begin
    case (cur_op)
      OP_PRUNE_LOW:  mark_now = 33'(self_c) < 33'(depth_floor);
      OP_PRUNE_TIPS: mark_now = !downany ? ({1'b0, upmax} > {self_c, 1'b0}) :
                                !upany ? ({1'b0, downmax} > {self_c, 1'b0}) : 1'b0;
      OP_PRUNE_DIFF: mark_now = (COUNT_BITS+3)'((upmax > downmax) ? upmax : downmax) >
                                (COUNT_BITS+3)'(self_c) * (COUNT_BITS+3)'(5);
      default:       mark_now = !other;
    endcase
  end

  logic is_prune;
  assign is_prune = (cur_op == OP_PRUNE_LOW) || (cur_op == OP_PRUNE_TIPS) ||
                    (cur_op == OP_PRUNE_DIFF) || (cur_op == OP_PRUNE_SINGLE);

  always_comb begin
    we = 1'b0; mwe = 1'b0; mwd = 1'b0; waddr = cur; wdata = '0; raddr = nb_addr;
    unique case (state)
      S_CLEAR: begin we = 1'b1; mwe = 1'b1; waddr = AW'(idx); end
      S_IDLE:  raddr = win_next & kmask;
      S_BWR:   begin we = ok_base && (rdata != CMAX); wdata = rdata + 1'b1; end
      S_EVAL:  begin mwe = is_prune; mwd = mark_now && (self_c != '0); end
      S_CREAD: raddr = AW'(idx);
      S_CWR:   begin we = mark_rd; mwe = mark_rd; waddr = AW'(idx); end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; idx <= '0; done <= 1'b0;
      kbases <= 4'd8; margin <= '0; end_mode <= 1'b0; depth_floor <= 16'd1;
      base_window <= '0; read_position <= '0;
      present <= 1'b0; kmer_count <= '0; upstream_mask <= '0; downstream_mask <= '0;
      max_count <= '0; removed_total <= '0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KMER_SIZE: kbases <= cfg_data[3:0];
          REG_MARGIN:    margin <= cfg_data;
          REG_END_MODE:  end_mode <= cfg_data[0];
          REG_MIN_DEPTH: depth_floor <= cfg_data[15:0];
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == TW'((2**AW) - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          cur_op <= op_t'(op);
          present <= 1'b0; kmer_count <= '0; upstream_mask <= '0; downstream_mask <= '0;
          max_count <= '0; removed_total <= '0;
          idx <= '0; step <= '0; removed <= '0; maxc <= '0;
          unique case (op_t'(op))
            OP_BASE: begin
              base_window <= win_next; read_position <= pos_next;
              ok_base <= ok_calc; cur <= win_next & kmask; state <= S_BASE;
            end
            OP_QUERY: begin
              cur <= AW'(query_kmer) & kmask; state <= S_NREQ;
            end
            OP_UNUSED: state <= S_DONE;
            default: begin cur <= '0; state <= S_NREQ; end
          endcase
        end
        S_BASE: state <= S_BWR;
        S_BWR: state <= S_DONE;
        S_NREQ: begin
          // read issued for step; reset gathers at step 0
          if (step == 4'd0) begin
            upmax <= '0; downmax <= '0; upany <= 1'b0; downany <= 1'b0; other <= 1'b0;
            um <= '0; dm <= '0;
          end
          state <= S_NWAIT;
        end
        S_NWAIT: begin
          if (step == 4'd0) begin
            self_c <= rdata;
            if (cur_op == OP_MAX_DEPTH) begin
              if (rdata > maxc) maxc <= rdata;
              state <= S_EVAL;
            end else if (cur_op == OP_PRUNE_LOW || (is_prune && rdata == '0))
              state <= S_EVAL;
            else begin step <= 4'd1; state <= S_NREQ; end
          end else begin
            if (rdata != '0) begin
              if (step <= 4'd4) begin
                upany <= 1'b1; um[nb_b] <= 1'b1;
                if (rdata > upmax) upmax <= rdata;
              end else begin
                downany <= 1'b1; dm[nb_b] <= 1'b1;
                if (rdata > downmax) downmax <= rdata;
              end
              if (nb_addr != cur) other <= 1'b1;
            end
            if (step == 4'd8) state <= S_EVAL;
            else begin step <= step + 1'b1; state <= S_NREQ; end
          end
        end
        S_EVAL: begin
          step <= '0;
          if (cur_op == OP_QUERY) begin
            present <= self_c != '0; kmer_count <= 16'(self_c);
            upstream_mask <= um; downstream_mask <= dm; state <= S_DONE;
          end else if (idx + 1'b1 == n_ent) begin
            idx <= '0;
            if (cur_op == OP_MAX_DEPTH) begin
              max_count <= 16'(maxc); state <= S_DONE;
            end else state <= S_CREAD;
          end else begin
            idx <= idx + 1'b1; cur <= AW'(idx + 1'b1); state <= S_NREQ;
          end
        end
        S_CREAD: state <= S_CWR;
        S_CWR: begin
          if (mark_rd) removed <= removed + 1'b1;
          if (idx + 1'b1 == n_ent) begin
            removed_total <= mark_rd ? removed + 1'b1 : removed;
            state <= S_DONE;
          end else begin idx <= idx + 1'b1; state <= S_CREAD; end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
